### hw/rtl/pts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler
// Task state codes, command codes, sequencer states, configuration register
// indexes and the per-slot request/response structs.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TASKS_DEFAULT = 8;

  localparam int CMD_W      = 2;
  localparam int MASK_W     = 8;
  localparam int TICK_W     = 16;
  localparam int SLICE_W    = 8;
  localparam int TASK_OUT_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int SLOT_IDX_W = 5;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE    = 2'd2;

  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_SUSPENDED = 2'd2
  } task_st_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_DELAY  = 2'd2,
    CMD_WAIT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_WALK   = 2'd1,
    S_FINISH = 2'd2,
    S_DONE   = 2'd3
  } seq_st_t;

  typedef struct packed {
    logic              present;
    logic              attached;
    logic              flag;
    task_st_t          state;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] length;
  } slot_in_t;

  typedef struct packed {
    task_st_t          state;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] length;
    logic              switch_req;
    logic              hit;
  } slot_out_t;

  // Bit of an 8-bit mask for a slot; slots past the mask width read as clear.
  function automatic logic slot_bit(input logic [MASK_W-1:0] mask,
                                    input logic [SLOT_IDX_W-1:0] idx);
    logic [2:0] low;
    low = idx[2:0];
    return (idx < SLOT_IDX_W'(MASK_W)) && mask[low];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pts_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_in_if: command channel of the priority task scheduler
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  event_flags;
  logic [15:0] delay_ticks;

  modport source (output valid, cmd, event_flags, delay_ticks, input ready);
  modport sink   (input valid, cmd, event_flags, delay_ticks, output ready);
endinterface
`default_nettype wire

### hw/rtl/pts_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_out_if: result channel of the priority task scheduler
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface pts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] current_task;
  logic       current_valid;
  logic       switch_request;
  logic [7:0] runnable_mask;

  modport source (output valid, current_task, current_valid, switch_request,
                  runnable_mask, input ready);
  modport sink   (input valid, current_task, current_valid, switch_request,
                  runnable_mask, output ready);
endinterface
`default_nettype wire

### hw/rtl/pts_slot_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_slot_unit: shared per-slot evaluation unit
// Applies one command to one task slot: delay expiry compare, event wake,
// select test, delay arm and event wait. Reused for every slot visited.
// ----------------------------------------------------------------------------
module pts_slot_unit (
  input  wire pts_pkg::cmd_t                    cmd,
  input  wire logic [pts_pkg::TICK_W-1:0]       tick_count,
  input  wire logic [pts_pkg::TICK_W-1:0]       delay_ticks,
  input  wire pts_pkg::slot_in_t                slot_in,
  output pts_pkg::slot_out_t                    slot_out
);

  logic [pts_pkg::TICK_W-1:0] elapsed;

  assign elapsed = tick_count - slot_in.start;

  always_comb begin
    slot_out.state      = slot_in.state;
    slot_out.start      = slot_in.start;
    slot_out.length     = slot_in.length;
    slot_out.switch_req = 1'b0;
    slot_out.hit        = 1'b0;
    unique case (cmd)
      pts_pkg::CMD_TICK: begin
        // Delay expiry first, then the event flag overrides the state.
        if (slot_in.present && slot_in.length != '0) begin
          if (elapsed >= slot_in.length) begin
            slot_out.start      = '0;
            slot_out.length     = '0;
            slot_out.state      = pts_pkg::ST_READY;
            slot_out.switch_req = 1'b1;
          end else begin
            slot_out.state = pts_pkg::ST_SUSPENDED;
          end
        end
        if (slot_in.present && slot_in.attached) begin
          if (slot_in.flag) begin
            slot_out.state      = pts_pkg::ST_READY;
            slot_out.switch_req = 1'b1;
          end else begin
            slot_out.state = pts_pkg::ST_SUSPENDED;
          end
        end
      end
      pts_pkg::CMD_SELECT: begin
        if (slot_in.present && (slot_in.state == pts_pkg::ST_READY ||
                                slot_in.state == pts_pkg::ST_RUNNING)) begin
          slot_out.state = pts_pkg::ST_RUNNING;
          slot_out.hit   = 1'b1;
        end
      end
      pts_pkg::CMD_DELAY: begin
        if (slot_in.present && delay_ticks != '0 && slot_in.length == '0) begin
          slot_out.length     = delay_ticks;
          slot_out.start      = tick_count;
          slot_out.state      = pts_pkg::ST_SUSPENDED;
          slot_out.switch_req = 1'b1;
        end
      end
      pts_pkg::CMD_WAIT: begin
        if (slot_in.present && slot_in.attached && !slot_in.flag) begin
          slot_out.state      = pts_pkg::ST_SUSPENDED;
          slot_out.switch_req = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/priority_task_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_task_scheduler: fixed-priority task scheduler with tick wake-up
// Keeps state, delay start and delay length per task slot (slot 0 is the
// highest priority) plus a 16-bit tick count, a time-slice counter and the
// running task. On a tick beat the sequencer walks every slot, one per cycle,
// through a single shared slot unit (expiry compare and event wake), then
// advances the tick and slice counters and loads the result register. A
// select beat walks slots from 0 until the first ready or running one. Delay
// and wait beats touch only the running slot. The next command is taken once
// the result sits in the output register, even while it waits to be taken.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the block is idle; the block does not enforce this.
// Indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
  parameter int TASKS = pts_pkg::TASKS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  pts_in_if.sink                                   in_if,
  pts_out_if.source                                out_if,
  input  wire logic                                cfg_we,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TASKS - 1);

  // Sequencer and command latch
  pts_pkg::seq_st_t state_r, state_nxt;
  pts_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [pts_pkg::MASK_W-1:0]  flags_r, flags_nxt;
  logic [pts_pkg::TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [IW-1:0]               walk_r, walk_nxt;
  logic                        sw_r, sw_nxt;

  // Scheduler state
  logic [pts_pkg::TICK_W-1:0]  tick_count_r, tick_count_nxt;
  logic [pts_pkg::SLICE_W-1:0] slice_count_r, slice_count_nxt;
  logic [IW-1:0]               running_idx_r, running_idx_nxt;
  logic                        running_valid_r, running_valid_nxt;

  // Configuration registers
  logic [pts_pkg::MASK_W-1:0]  present_mask_r;
  logic [pts_pkg::MASK_W-1:0]  attached_mask_r;
  logic [pts_pkg::SLICE_W-1:0] slice_ticks_r;

  // Slot table
  pts_pkg::task_st_t           task_state_r   [TASKS];
  logic [pts_pkg::TICK_W-1:0]  delay_start_r  [TASKS];
  logic [pts_pkg::TICK_W-1:0]  delay_length_r [TASKS];

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_task_r, out_task_nxt;
  logic                        out_cur_valid_r, out_cur_valid_nxt;
  logic                        out_sw_r, out_sw_nxt;
  logic [pts_pkg::MASK_W-1:0]  out_runnable_r, out_runnable_nxt;

  logic                        slot_we;
  logic [IW-1:0]               addr;
  logic [pts_pkg::SLOT_IDX_W-1:0] addr_ext;
  logic [pts_pkg::SLOT_IDX_W-1:0] run_ext;
  logic                        on_running;
  pts_pkg::slot_in_t           slot_in;
  pts_pkg::slot_out_t          slot_out;
  logic [pts_pkg::MASK_W-1:0]  runnable;
  logic [pts_pkg::SLICE_W-1:0] slice_inc;

  // Delay and wait act on the running slot; tick and select walk the table.
  assign on_running = (cmd_r == pts_pkg::CMD_DELAY) || (cmd_r == pts_pkg::CMD_WAIT);
  assign addr       = on_running ? running_idx_r : walk_r;
  assign addr_ext   = pts_pkg::SLOT_IDX_W'(addr);
  assign run_ext    = pts_pkg::SLOT_IDX_W'(running_idx_r);

  always_comb begin
    slot_in.present  = pts_pkg::slot_bit(present_mask_r, addr_ext) &&
                       (!on_running || running_valid_r);
    slot_in.attached = pts_pkg::slot_bit(attached_mask_r, addr_ext);
    slot_in.flag     = pts_pkg::slot_bit(flags_r, addr_ext);
    slot_in.state    = task_state_r[addr];
    slot_in.start    = delay_start_r[addr];
    slot_in.length   = delay_length_r[addr];
  end

  pts_slot_unit u_slot (
    .cmd         (cmd_r),
    .tick_count  (tick_count_r),
    .delay_ticks (ticks_r),
    .slot_in     (slot_in),
    .slot_out    (slot_out)
  );

  // Runnable view: present slots in ready or running state.
  always_comb begin
    runnable = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (i < pts_pkg::MASK_W) begin
        runnable[i[2:0]] = pts_pkg::slot_bit(present_mask_r,
                                             pts_pkg::SLOT_IDX_W'(i)) &&
                           (task_state_r[i[IW-1:0]] == pts_pkg::ST_READY ||
                            task_state_r[i[IW-1:0]] == pts_pkg::ST_RUNNING);
      end
    end
  end

  assign slice_inc = slice_count_r + 1'b1;

  // Next state and outputs
  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    flags_nxt         = flags_r;
    ticks_nxt         = ticks_r;
    walk_nxt          = walk_r;
    sw_nxt            = sw_r;
    tick_count_nxt    = tick_count_r;
    slice_count_nxt   = slice_count_r;
    running_idx_nxt   = running_idx_r;
    running_valid_nxt = running_valid_r;
    out_task_nxt      = out_task_r;
    out_cur_valid_nxt = out_cur_valid_r;
    out_sw_nxt        = out_sw_r;
    out_runnable_nxt  = out_runnable_r;
    slot_we           = 1'b0;
    in_if.ready       = 1'b0;

    // Drop the result beat once taken.
    out_valid_nxt = out_valid_r && !out_if.ready;

    unique case (state_r)
      pts_pkg::S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cmd_nxt   = pts_pkg::cmd_t'(in_if.cmd);
          flags_nxt = in_if.event_flags;
          ticks_nxt = in_if.delay_ticks;
          walk_nxt  = '0;
          sw_nxt    = 1'b0;
          state_nxt = pts_pkg::S_WALK;
        end
      end
      pts_pkg::S_WALK: begin
        slot_we = 1'b1;
        sw_nxt  = sw_r | slot_out.switch_req;
        unique case (cmd_r)
          pts_pkg::CMD_TICK: begin
            if (walk_r == LAST_SLOT) begin
              state_nxt = pts_pkg::S_FINISH;
            end else begin
              walk_nxt = walk_r + 1'b1;
            end
          end
          pts_pkg::CMD_SELECT: begin
            // Stop at the first runnable slot: it becomes the running task.
            if (slot_out.hit) begin
              running_idx_nxt   = addr;
              running_valid_nxt = 1'b1;
              state_nxt         = pts_pkg::S_FINISH;
            end else if (walk_r == LAST_SLOT) begin
              state_nxt = pts_pkg::S_FINISH;
            end else begin
              walk_nxt = walk_r + 1'b1;
            end
          end
          pts_pkg::CMD_DELAY,
          pts_pkg::CMD_WAIT: begin
            state_nxt = pts_pkg::S_FINISH;
          end
          default: begin
            state_nxt = pts_pkg::S_FINISH;
          end
        endcase
      end
      pts_pkg::S_FINISH: begin
        // On a tick beat, advance tick and slice counters; a full slice requests a switch.
        if (cmd_r == pts_pkg::CMD_TICK) begin
          tick_count_nxt = tick_count_r + 1'b1;
          if (slice_inc >= slice_ticks_r) begin
            slice_count_nxt = '0;
            sw_nxt          = 1'b1;
          end else begin
            slice_count_nxt = slice_inc;
          end
        end
        state_nxt = pts_pkg::S_DONE;
      end
      pts_pkg::S_DONE: begin
        // Hold until the result register is free.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt     = 1'b1;
          out_task_nxt      = run_ext[2:0];
          out_cur_valid_nxt = running_valid_r;
          out_sw_nxt        = sw_r;
          out_runnable_nxt  = runnable;
          state_nxt         = pts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pts_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= pts_pkg::S_IDLE;
      tick_count_r    <= '0;
      slice_count_r   <= '0;
      running_idx_r   <= '0;
      running_valid_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      tick_count_r    <= tick_count_nxt;
      slice_count_r   <= slice_count_nxt;
      running_idx_r   <= running_idx_nxt;
      running_valid_r <= running_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    flags_r         <= flags_nxt;
    ticks_r         <= ticks_nxt;
    walk_r          <= walk_nxt;
    sw_r            <= sw_nxt;
    out_task_r      <= out_task_nxt;
    out_cur_valid_r <= out_cur_valid_nxt;
    out_sw_r        <= out_sw_nxt;
    out_runnable_r  <= out_runnable_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_mask_r  <= '0;
      attached_mask_r <= '0;
      slice_ticks_r   <= pts_pkg::SLICE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pts_pkg::CFG_PRESENT:  present_mask_r  <= cfg_data;
        pts_pkg::CFG_ATTACHED: attached_mask_r <= cfg_data;
        pts_pkg::CFG_SLICE:    slice_ticks_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Slot table: reset to ready with no delay; write back the visited slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        task_state_r[i]   <= pts_pkg::ST_READY;
        delay_start_r[i]  <= '0;
        delay_length_r[i] <= '0;
      end
    end else if (slot_we) begin
      task_state_r[addr]   <= slot_out.state;
      delay_start_r[addr]  <= slot_out.start;
      delay_length_r[addr] <= slot_out.length;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.current_task   = out_task_r;
  assign out_if.current_valid  = out_cur_valid_r;
  assign out_if.switch_request = out_sw_r;
  assign out_if.runnable_mask  = out_runnable_r;

  // Assertions
  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> state_r == pts_pkg::S_WALK)
    else $error("accepted command did not start the slot walk");

  a_running_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(running_valid_r))
    else $error("running task selection was lost");

  a_single_slot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pts_pkg::S_WALK && on_running) |=> state_r == pts_pkg::S_FINISH)
    else $error("delay or wait visited more than one slot");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pts_pkg::S_FINISH && cmd_r == pts_pkg::CMD_TICK) |=>
      tick_count_r == $past(tick_count_r) + 16'd1)
    else $error("tick did not advance the tick count by one");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pts_pkg::S_IDLE) |-> !in_if.ready)
    else $error("command taken while the sequencer is busy");

endmodule
`default_nettype wire
